/* hdl/fixed_point_to_seven_segment_defines.svh */
// assertion macros shared by the display writer rtl
`ifndef FIXED_POINT_TO_SEVEN_SEGMENT_DEFINES_SVH
`define FIXED_POINT_TO_SEVEN_SEGMENT_DEFINES_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

/* hdl/fp7s_pkg.sv */
`default_nettype none
package fp7s_pkg;

   localparam int SCALED_W    = 24;
   localparam int MAG_W       = 20;
   localparam int ADDR_W      = 4;
   localparam int SEG_W       = 8;
   localparam int DIGITS_W    = 2;
   localparam int DIGIT_W     = 4;
   localparam int NUM_CHARS   = 6;
   localparam int CHAR_IDX_W  = 3;
   localparam int DP_BIT      = 7;

   localparam logic signed [SCALED_W-1:0] SAT_HIGH = 24'sd999999;
   localparam logic signed [SCALED_W-1:0] SAT_LOW  = -24'sd99999;

   localparam logic [SEG_W-1:0] SEG_MINUS = 8'h02;
   localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

   // x/10 == (x * RECIP) >> RECIP_SHIFT for every x below 10^6
   localparam logic [MAG_W-1:0] RECIP       = 20'd838861;
   localparam int               RECIP_SHIFT = 23;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_WORD_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_WORD_W-1:0] REG_DECIMAL_DIGITS = 1'b0;
   localparam logic [DIGITS_W-1:0]   DIGITS_RESET       = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IDX_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef struct packed {
      logic [MAG_W-1:0]    mag;
      logic                neg;
      logic                zpad;
      logic [DIGITS_W-1:0] digits;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

   function automatic logic [SEG_W-1:0] digit_seg(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] seg;
      case (digit)
         4'd0: seg = 8'h7D;
         4'd1: seg = 8'h60;
         4'd2: seg = 8'h3E;
         4'd3: seg = 8'h7A;
         4'd4: seg = 8'h63;
         4'd5: seg = 8'h5B;
         4'd6: seg = 8'h5F;
         4'd7: seg = 8'h70;
         4'd8: seg = 8'h7F;
         4'd9: seg = 8'h7B;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

   function automatic logic [MAG_W-1:0] pow_ten(input logic [DIGITS_W-1:0] digits);
      logic [MAG_W-1:0] p;
      case (digits)
         2'd0: p = 20'd1;
         2'd1: p = 20'd10;
         2'd2: p = 20'd100;
         2'd3: p = 20'd1000;
         default: p = 20'd1;
      endcase
      return p;
   endfunction

endpackage
`default_nettype wire

/* hdl/fixed_point_to_seven_segment.sv */
`default_nettype none
// channel   direction  handshake                     payload
// req       in         req_valid / req_ready         req_scaled_value
// rsp       out        rsp_valid / rsp_ready         rsp_ram_address, rsp_segment_byte,
//                                                    rsp_last_write
// csr       in         psel / penable / pready       paddr, pwdata, pwrite, prdata
//
// each item gives six writes, one per cycle while rsp_ready does not stall them;
// the divide-by-ten in the back end yields one digit per write
// a two-entry queue takes new items while the back end is still writing
// an accepted item passes the queue and the writer state before its first write is registered on rsp
// reset is synchronous and clears the queue, the writer and decimal_digits to 3
// a stalled rsp holds its write; items pile up in the queue until it is full
module fixed_point_to_seven_segment (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [fp7s_pkg::SCALED_W-1:0] req_scaled_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic             [fp7s_pkg::ADDR_W-1:0]   rsp_ram_address,
   output logic             [fp7s_pkg::SEG_W-1:0]    rsp_segment_byte,
   output logic                                      rsp_last_write,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic        [fp7s_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic        [fp7s_pkg::CSR_DATA_W-1:0] pwdata,
   output logic             [fp7s_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                      pready
);
   import fp7s_pkg::*;

   logic [DIGITS_W-1:0] digits;
   logic                queue_full;
   logic                push;
   logic                pop;
   entry_type           entry;
   queue_head_type      head;

   fp7s_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .digits  (digits)
   );

   fp7s_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_scaled_value (req_scaled_value),
      .digits           (digits),
      .queue_full       (queue_full),
      .push             (push),
      .entry            (entry)
   );

   fp7s_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head)
   );

   fp7s_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ram_address  (rsp_ram_address),
      .rsp_segment_byte (rsp_segment_byte),
      .rsp_last_write   (rsp_last_write)
   );

endmodule
`default_nettype wire

/* hdl/fp7s_csr.sv */
`default_nettype none
module fp7s_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [fp7s_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [fp7s_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [fp7s_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                   pready,
   output logic      [fp7s_pkg::DIGITS_W-1:0]     digits
);
   import fp7s_pkg::*;

   logic [DIGITS_W-1:0]   digits_ff;
   logic [DIGITS_W-1:0]   digits_in;
   logic [CSR_WORD_W-1:0] word;
   logic                  hit;

   assign word = paddr[CSR_ADDR_W-1:2];
   assign hit  = (word == REG_DECIMAL_DIGITS);

   always_comb begin
      digits_in = digits_ff;
      if (psel && penable && pwrite && hit) begin
         digits_in = pwdata[DIGITS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff <= DIGITS_RESET;
      end else begin
         digits_ff <= digits_in;
      end
   end

   assign prdata = hit ? {{(CSR_DATA_W-DIGITS_W){1'b0}}, digits_ff} : '0;
   assign pready = 1'b1;
   assign digits = digits_ff;

endmodule
`default_nettype wire

/* hdl/fp7s_front.sv */
`default_nettype none
module fp7s_front (
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [fp7s_pkg::SCALED_W-1:0] req_scaled_value,
   input  wire logic        [fp7s_pkg::DIGITS_W-1:0] digits,
   input  wire logic                                 queue_full,
   output logic                                      push,
   output fp7s_pkg::entry_type                       entry
);
   import fp7s_pkg::*;

   logic signed [SCALED_W-1:0] sat;
   logic        [SCALED_W-1:0] abs_val;
   logic                       neg;
   logic        [MAG_W-1:0]    mag;

   always_comb begin
      if (req_scaled_value > SAT_HIGH) begin
         sat = SAT_HIGH;
      end else if (req_scaled_value < SAT_LOW) begin
         sat = SAT_LOW;
      end else begin
         sat = req_scaled_value;
      end
   end

   assign neg     = sat[SCALED_W-1];
   assign abs_val = neg ? SCALED_W'(-sat) : SCALED_W'(sat);
   assign mag     = abs_val[MAG_W-1:0];

   always_comb begin
      entry.mag    = mag;
      entry.neg    = neg;
      // with decimal digits set, values below one (mag under 10^digits) are shown zero padded
      entry.zpad   = (digits != '0) && (mag < pow_ten(digits));
      entry.digits = digits;
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

endmodule
`default_nettype wire

/* hdl/fp7s_queue.sv */
`default_nettype none
`include "fixed_point_to_seven_segment_defines.svh"
module fp7s_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire fp7s_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output fp7s_pkg::queue_head_type head
);
   import fp7s_pkg::*;

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_IDX_W-1:0] rd_ptr_ff;
   logic [QUEUE_IDX_W-1:0] rd_ptr_in;
   logic [QUEUE_IDX_W-1:0] wr_ptr_ff;
   logic [QUEUE_IDX_W-1:0] wr_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   `ASSERT_IMPLIES(queue_no_overflow, clock, reset, push && !pop, !full)

endmodule
`default_nettype wire

/* hdl/fp7s_back.sv */
`default_nettype none
`include "fixed_point_to_seven_segment_defines.svh"
module fp7s_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fp7s_pkg::queue_head_type      head,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [fp7s_pkg::ADDR_W-1:0]        rsp_ram_address,
   output logic [fp7s_pkg::SEG_W-1:0]         rsp_segment_byte,
   output logic                               rsp_last_write
);
   import fp7s_pkg::*;

   logic                  busy_ff, busy_in;
   logic [CHAR_IDX_W-1:0] k_ff, k_in;
   logic [MAG_W-1:0]      r_ff, r_in;
   logic                  neg_ff, neg_in;
   logic                  zpad_ff, zpad_in;
   logic [DIGITS_W-1:0]   digits_ff, digits_in;
   logic                  minus_done_ff, minus_done_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [SEG_W-1:0]      rsp_seg_ff, rsp_seg_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  advance;
   logic                  last_step;
   logic [CHAR_IDX_W-1:0] idx;
   logic [2*MAG_W-1:0]    prod;
   logic [MAG_W-1:0]      quot;
   logic [MAG_W-1:0]      rem_full;
   logic [DIGIT_W-1:0]    digit;
   logic [CHAR_IDX_W:0]   idx_plus_d;
   logic [SEG_W-1:0]      seg;
   logic                  place_minus;

   assign advance   = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign last_step = (k_ff == CHAR_IDX_W'(NUM_CHARS - 1));
   assign pop       = head.valid && (!busy_ff || (advance && last_step));
   assign idx       = CHAR_IDX_W'(NUM_CHARS - 1) - k_ff;

   // one decimal digit per write, least significant first
   assign prod     = r_ff * RECIP;
   assign quot     = MAG_W'(prod >> RECIP_SHIFT);
   assign rem_full = r_ff - ((quot << 3) + (quot << 1));
   assign digit    = rem_full[DIGIT_W-1:0];

   assign idx_plus_d = {1'b0, idx} + {{(CHAR_IDX_W-DIGITS_W+1){1'b0}}, digits_ff};

   always_comb begin
      place_minus = 1'b0;
      if (zpad_ff) begin
         if (neg_ff && idx == '0) begin
            seg = SEG_MINUS;
         end else if (!neg_ff && idx_plus_d <= (CHAR_IDX_W+1)'(4)) begin
            seg = SEG_BLANK;
         end else begin
            seg = digit_seg(digit);
         end
      end else begin
         if (r_ff != '0 || k_ff == '0) begin
            seg = digit_seg(digit);
         end else if (neg_ff && !minus_done_ff) begin
            seg         = SEG_MINUS;
            place_minus = 1'b1;
         end else begin
            seg = SEG_BLANK;
         end
      end
      if (digits_ff != '0 && idx_plus_d == (CHAR_IDX_W+1)'(6)) begin
         seg[DP_BIT] = 1'b1;
      end
   end

   always_comb begin
      busy_in       = busy_ff;
      k_in          = k_ff;
      r_in          = r_ff;
      neg_in        = neg_ff;
      zpad_in       = zpad_ff;
      digits_in     = digits_ff;
      minus_done_in = minus_done_ff;
      if (pop) begin
         busy_in       = 1'b1;
         k_in          = '0;
         r_in          = head.entry.mag;
         neg_in        = head.entry.neg;
         zpad_in       = head.entry.zpad;
         digits_in     = head.entry.digits;
         minus_done_in = 1'b0;
      end else if (advance && last_step) begin
         busy_in = 1'b0;
      end else if (advance) begin
         k_in          = k_ff + 1'b1;
         r_in          = quot;
         minus_done_in = minus_done_ff || place_minus;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_seg_in   = rsp_seg_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = {k_ff, 1'b0};
         rsp_seg_in   = seg;
         rsp_last_in  = last_step;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         k_ff          <= '0;
         minus_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         k_ff          <= k_in;
         minus_done_ff <= minus_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      neg_ff      <= neg_in;
      zpad_ff     <= zpad_in;
      digits_ff   <= digits_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_seg_ff  <= rsp_seg_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ram_address  = rsp_addr_ff;
   assign rsp_segment_byte = rsp_seg_ff;
   assign rsp_last_write   = rsp_last_ff;

   `ASSERT_IMPLIES(last_at_top_address, clock, reset, rsp_valid_ff && rsp_last_ff,
      rsp_addr_ff == ADDR_W'(2 * (NUM_CHARS - 1)))
   `ASSERT_NEXT(restart_at_address_zero, clock, reset, rsp_valid_ff && rsp_ready && rsp_last_ff,
      !rsp_valid_ff || rsp_addr_ff == '0)
   `ASSERT_IMPLIES(minus_clear_on_first, clock, reset, busy_ff && k_ff == '0, !minus_done_ff)

endmodule
`default_nettype wire
